// File: hdl/lmps_pkg.sv
// ----------------------------------------------------------------------------
// lmps_pkg
// Shared constants and types of the LED matrix PWM scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lmps_pkg;

   localparam int PWM_STEPS    = 32;
   localparam int HALF_COLUMNS = 7;
   localparam int MATRIX_ROWS  = 5;
   localparam int MATRIX_COLS  = 2 * HALF_COLUMNS;
   localparam int LANES        = 2 * MATRIX_ROWS;
   localparam int STEP_SIZE    = 256 / PWM_STEPS;

   localparam int STEP_W  = (PWM_STEPS > 2) ? $clog2(PWM_STEPS) : 1;
   localparam int LEVEL_W = 9;
   localparam int COL_W   = $clog2(HALF_COLUMNS + 1);
   localparam int LANE_W  = $clog2(LANES);
   localparam int ADDR_W  = $clog2(HALF_COLUMNS);
   localparam int WORD_W  = 24;

   localparam logic [HALF_COLUMNS-1:0] COL_MASK = '1;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef logic [LANES-1:0][7:0] pixel_row_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [LANE_W-1:0] lane;
      logic [7:0]        data;
   } wr_req_type;

   typedef struct packed {
      logic               blank;
      logic               done;
      logic [COL_W-1:0]   col;
      logic [LEVEL_W-1:0] level;
   } line_ctl_type;

endpackage

`default_nettype wire

// File: hdl/lmps_if.sv
// ----------------------------------------------------------------------------
// lmps_req_if / lmps_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmps_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [2:0] pixel_row;
   logic [3:0] pixel_col;
   logic [7:0] pixel_value;

   modport source (output valid, op, pixel_row, pixel_col, pixel_value, input ready);
   modport sink   (input valid, op, pixel_row, pixel_col, pixel_value, output ready);
endinterface

interface lmps_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] shift_word;
   logic        blank_line;
   logic        frame_done;

   modport source (output valid, shift_word, blank_line, frame_done, input ready);
   modport sink   (input valid, shift_word, blank_line, frame_done, output ready);
endinterface

`default_nettype wire

// File: hdl/lmps_frame_store.sv
// ----------------------------------------------------------------------------
// lmps_frame_store
// Pixel memory, one word per scan column holding both halves of every row,
// with per-pixel valid bits so the store reads dark after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lmps_frame_store (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lmps_pkg::wr_req_type              wr,
   input  wire logic                              rd_en,
   input  wire logic [lmps_pkg::ADDR_W-1:0]       rd_addr,
   output      lmps_pkg::pixel_row_type           rd_data
);
   import lmps_pkg::*;

   pixel_row_type                           mem [HALF_COLUMNS];
   logic [HALF_COLUMNS-1:0][LANES-1:0]      vld_ff;
   logic [HALF_COLUMNS-1:0][LANES-1:0]      vld_in;
   pixel_row_type                           rd_ff;
   logic [LANES-1:0]                        rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.addr][wr.lane] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr][wr.lane] <= wr.data;
      end
      if (rd_en) begin
         rd_ff     <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rd_data[i] = rd_vld_ff[i] ? rd_ff[i] : 8'h00;
      end
   end

endmodule

`default_nettype wire

// File: hdl/lmps_line_pack.sv
// ----------------------------------------------------------------------------
// lmps_line_pack
// Threshold compare of one column of pixels and packing of the line word.
// ----------------------------------------------------------------------------
`default_nettype none

module lmps_line_pack (
   input  wire lmps_pkg::pixel_row_type         pixels,
   input  wire lmps_pkg::line_ctl_type          ctl,
   output      logic [lmps_pkg::WORD_W-1:0]     word
);
   import lmps_pkg::*;

   logic [MATRIX_ROWS-1:0]  left;
   logic [MATRIX_ROWS-1:0]  right;
   logic [HALF_COLUMNS-1:0] sel;
   logic [HALF_COLUMNS-1:0] onehot;

   always_comb begin
      left   = '0;
      right  = '0;
      onehot = '0;
      sel    = COL_MASK;
      if (!ctl.blank) begin
         // bit i carries row 4-i, bottom row in bit 0
         for (int i = 0; i < MATRIX_ROWS; i++) begin
            left[i]  = {1'b0, pixels[MATRIX_ROWS-1-i]} > ctl.level;
            right[i] = {1'b0, pixels[2*MATRIX_ROWS-1-i]} > ctl.level;
         end
         onehot[ctl.col[ADDR_W-1:0]] = 1'b1;
         sel = onehot ^ COL_MASK;
      end
      word = {sel, right, sel, left};
   end

endmodule

`default_nettype wire

// File: hdl/led_matrix_pwm_scan_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_pwm_scan_unit
// Frame store and scan sequencer for a two-half multiplexed LED matrix.
//
// The req channel carries pixel writes (op 0) and scan ticks (op 1). A write
// stores one pixel and gives no response word; writes outside the matrix are
// dropped. Each tick gives one rsp word: the 24-bit shift word of the current
// scan column at the current PWM step, with flags for the blanking line and
// for the last line of a frame.
// A tick's word passes the frame store read register, then the line word
// register, before rsp valid rises. One word is accepted every cycle while
// rsp is not stalled; a tick of a visible column makes a single memory read
// that fetches a whole column of both halves. A write followed directly by
// a tick is seen by that tick.
// Reset clears the frame store valid bits, so every pixel reads as zero, and
// sets the scan to column 0, step 0. While rsp is stalled, one tick can wait
// in the read stage behind the held response; beyond that req.ready drops,
// and writes wait with it.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_pwm_scan_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   lmps_req_if.sink   req_bus,
   lmps_rsp_if.source rsp_bus
);
   import lmps_pkg::*;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               s1_valid_ff, s1_valid_in;
   line_ctl_type       s1_ctl_ff;
   line_ctl_type       s1_ctl_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  word_ff;
   logic               blank_ff;
   logic               done_ff;

   logic               advance;
   logic               accept;
   logic               tick;
   logic               is_blank;
   logic               last_step;
   logic               right_half;
   wr_req_type         wr;
   pixel_row_type      pixels;
   logic [WORD_W-1:0]  word;

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept = req_bus.valid && req_bus.ready;
   assign tick = accept && (req_bus.op == OP_TICK);

   assign is_blank  = (col_ff >= COL_W'(HALF_COLUMNS));
   assign last_step = (step_ff == STEP_W'(PWM_STEPS - 1));

   // pixel write address: word per column in half, lane per row and half
   assign right_half = (req_bus.pixel_col >= 4'(HALF_COLUMNS));
   always_comb begin
      wr.en   = accept && (req_bus.op == OP_WRITE)
             && (req_bus.pixel_row < 3'(MATRIX_ROWS))
             && (req_bus.pixel_col < 4'(MATRIX_COLS));
      wr.addr = right_half ? ADDR_W'(req_bus.pixel_col - 4'(HALF_COLUMNS))
                           : ADDR_W'(req_bus.pixel_col);
      wr.lane = right_half ? LANE_W'(req_bus.pixel_row) + LANE_W'(MATRIX_ROWS)
                           : LANE_W'(req_bus.pixel_row);
      wr.data = req_bus.pixel_value;
   end

   lmps_frame_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (tick && !is_blank),
      .rd_addr (col_ff[ADDR_W-1:0]),
      .rd_data (pixels)
   );

   always_comb begin
      col_in  = col_ff;
      step_in = step_ff;
      if (tick) begin
         if (is_blank) begin
            col_in  = '0;
            step_in = last_step ? '0 : step_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_ctl_in.blank = is_blank;
      s1_ctl_in.done  = is_blank && last_step;
      s1_ctl_in.col   = col_ff;
      s1_ctl_in.level = LEVEL_W'((LEVEL_W'(PWM_STEPS) - LEVEL_W'(step_ff))
                                 * LEVEL_W'(STEP_SIZE));
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (tick) begin
         s1_valid_in = 1'b1;
      end else if (s1_valid_ff && advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   lmps_line_pack u_pack (
      .pixels (pixels),
      .ctl    (s1_ctl_ff),
      .word   (word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         step_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         step_ff      <= step_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         s1_ctl_ff <= s1_ctl_in;
      end
      if (advance && s1_valid_ff) begin
         word_ff  <= word;
         blank_ff <= s1_ctl_ff.blank;
         done_ff  <= s1_ctl_ff.done;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.shift_word = word_ff;
   assign rsp_bus.blank_line = blank_ff;
   assign rsp_bus.frame_done = done_ff;

   // scan column stays within the visible columns plus the blanking line
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(HALF_COLUMNS))
      else $error("scan column out of range");

   // a blanking tick restarts the scan at column zero
   a_blank_wrap: assert property (@(posedge clock) disable iff (reset)
      tick && is_blank |=> col_ff == '0)
      else $error("scan did not wrap after blanking line");

   // frame end is only flagged on a blanking line
   a_done_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> blank_ff)
      else $error("frame done without blanking line");

   // no request is taken while the read stage is full and cannot drain
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |-> !accept)
      else $error("request accepted into a stalled read stage");

endmodule

`default_nettype wire

// File: dv/led_matrix_pwm_scan_unit_tb.sv
// ----------------------------------------------------------------------------
// led_matrix_pwm_scan_unit_tb
// Self-checking bench for the LED matrix PWM scan unit. Pixel writes and scan
// ticks are pushed through the req channel with random gaps, and rsp words are
// taken with random stalls. A line tracker keeps its own frame store, scan
// column and PWM step, predicts the shift word and flags of every tick, and
// compares each rsp word field by field against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [23:0] shift_word;
   logic        blank_line;
   logic        frame_done;
} scan_line_type;

class line_word_tracker;
   logic [7:0]                  pixels [lmps_pkg::MATRIX_ROWS * lmps_pkg::MATRIX_COLS];
   logic [lmps_pkg::COL_W-1:0]  column;
   logic [lmps_pkg::STEP_W-1:0] step;
   scan_line_type               lines_due [$];
   int                          errors;
   int                          writes;
   int                          dropped_writes;
   int                          ticks;
   int                          blanks;
   int                          frames;

   function new();
      foreach (pixels[i]) pixels[i] = 8'd0;
      column = '0;
      step   = '0;
      errors = 0;
      writes = 0;
      dropped_writes = 0;
      ticks  = 0;
      blanks = 0;
      frames = 0;
   endfunction

   function scan_line_type predict_line();
      scan_line_type line;
      int            level;
      int            r;
      logic [4:0]    left;
      logic [4:0]    right;
      logic [6:0]    sel;
      line.blank_line = (column >= lmps_pkg::HALF_COLUMNS);
      line.frame_done = line.blank_line && (step == lmps_pkg::PWM_STEPS - 1);
      level = (lmps_pkg::PWM_STEPS - int'(step)) * (256 / lmps_pkg::PWM_STEPS);
      left  = '0;
      right = '0;
      sel   = lmps_pkg::COL_MASK;
      if (!line.blank_line) begin
         for (int i = 0; i < lmps_pkg::MATRIX_ROWS; i++) begin
            r = lmps_pkg::MATRIX_ROWS - 1 - i;
            if (int'(pixels[r * lmps_pkg::MATRIX_COLS + column]) > level)
               left[i] = 1'b1;
            if (int'(pixels[r * lmps_pkg::MATRIX_COLS + lmps_pkg::HALF_COLUMNS + column]) > level)
               right[i] = 1'b1;
         end
         sel = lmps_pkg::COL_MASK ^ (7'd1 << column);
      end
      line.shift_word = {sel, right, sel, left};
      if (line.blank_line) begin
         column = '0;
         step   = (step == lmps_pkg::PWM_STEPS - 1) ? '0 : step + 1'b1;
      end else begin
         column = column + 1'b1;
      end
      return line;
   endfunction

   function void take_request(logic op, logic [2:0] row, logic [3:0] col, logic [7:0] value);
      scan_line_type line;
      if (op == lmps_pkg::OP_WRITE) begin
         writes++;
         if (row < lmps_pkg::MATRIX_ROWS && col < lmps_pkg::MATRIX_COLS)
            pixels[row * lmps_pkg::MATRIX_COLS + col] = value;
         else
            dropped_writes++;
      end else begin
         ticks++;
         line = predict_line();
         if (line.blank_line) blanks++;
         if (line.frame_done) frames++;
         lines_due.push_back(line);
      end
   endfunction

   function void match_line(logic [23:0] shift_word, logic blank_line, logic frame_done);
      scan_line_type want;
      if (lines_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected rsp word, shift_word %h", $time, shift_word);
         return;
      end
      want = lines_due.pop_front();
      if (shift_word !== want.shift_word) begin
         errors++;
         $display("%0t: shift_word expected %h actual %h",
                  $time, want.shift_word, shift_word);
      end
      if (blank_line !== want.blank_line) begin
         errors++;
         $display("%0t: blank_line expected %b actual %b",
                  $time, want.blank_line, blank_line);
      end
      if (frame_done !== want.frame_done) begin
         errors++;
         $display("%0t: frame_done expected %b actual %b",
                  $time, want.frame_done, frame_done);
      end
   endfunction
endclass

module led_matrix_pwm_scan_unit_tb;
   import lmps_pkg::*;

   localparam int RANDOM_ITEMS  = 1320;
   localparam int SEGMENT_ITEMS = 40;
   localparam int QUIET_ITEMS   = 160;
   localparam int HOLD_CYCLES   = 80;
   localparam int IDLE_LIMIT    = 2000;

   logic clock = 1'b0;
   logic reset;

   lmps_req_if req_if ();
   lmps_rsp_if rsp_if ();

   led_matrix_pwm_scan_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   line_word_tracker tracker = new();

   bit quiet         = 1'b0;
   bit hold_request  = 1'b0;
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int idle_cycles   = 0;
   int random_done   = 0;

   always #5 clock = ~clock;

   task automatic push_word(input logic op, input logic [2:0] row,
                            input logic [3:0] col, input logic [7:0] value);
      req_if.valid       <= 1'b1;
      req_if.op          <= op;
      req_if.pixel_row   <= row;
      req_if.pixel_col   <= col;
      req_if.pixel_value <= value;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic push_tick();
      push_word(OP_TICK, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                8'($urandom_range(0, 255)));
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 99) < req_gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.lines_due.size() != 0) @(posedge clock);
   endtask

   // one random word; returns 0 when it was an off-matrix write
   task automatic push_random(output bit counted);
      logic [2:0] row;
      logic [3:0] col;
      logic [7:0] value;
      int         pick;
      pick    = $urandom_range(0, 99);
      counted = 1'b1;
      if (pick < 65) begin
         push_tick();
      end else begin
         row = 3'($urandom_range(0, MATRIX_ROWS - 1));
         col = 4'($urandom_range(0, MATRIX_COLS - 1));
         if ($urandom_range(0, 4) == 0) begin
            value = 8'((($urandom_range(0, 32) * STEP_SIZE) + $urandom_range(0, 1)) & 8'hFF);
         end else begin
            value = 8'($urandom_range(0, 255));
         end
         if (pick >= 95) begin
            counted = 1'b0;
            if ($urandom_range(0, 1)) row = 3'($urandom_range(MATRIX_ROWS, 7));
            else                      col = 4'($urandom_range(MATRIX_COLS, 15));
         end
         push_word(OP_WRITE, row, col, value);
      end
   endtask

   // rsp side
   initial begin
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            tracker.match_line(rsp_if.shift_word, rsp_if.blank_line, rsp_if.frame_done);
         if (req_if.valid && req_if.ready)
            tracker.take_request(req_if.op, req_if.pixel_row, req_if.pixel_col,
                                 req_if.pixel_value);
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("led_matrix_pwm_scan_unit_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      bit counted;
      int seg_count;
      int seg;
      req_if.valid       <= 1'b0;
      req_if.op          <= OP_WRITE;
      req_if.pixel_row   <= 3'd0;
      req_if.pixel_col   <= 4'd0;
      req_if.pixel_value <= 8'd0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, off-matrix writes, a dark scan at step 0
      push_word(OP_WRITE, 3'd0, 4'd0,  8'd255);
      push_word(OP_WRITE, 3'd4, 4'd13, 8'd255);
      push_word(OP_WRITE, 3'd4, 4'd0,  8'd1);
      push_word(OP_WRITE, 3'd0, 4'd13, 8'd0);
      push_word(OP_WRITE, 3'd2, 4'd7,  8'd200);
      push_word(OP_WRITE, 3'd3, 4'd6,  8'd128);
      push_word(OP_WRITE, 3'd5, 4'd0,  8'd255);
      push_word(OP_WRITE, 3'd7, 4'd15, 8'd255);
      push_word(OP_WRITE, 3'd0, 4'd14, 8'd255);
      push_word(OP_WRITE, 3'd1, 4'd8,  8'd170);
      repeat (HALF_COLUMNS + 1) push_word(OP_TICK, 3'd7, 4'd15, 8'd255);
      push_word(OP_WRITE, 3'd1, 4'd1,  8'd255);
      push_word(OP_TICK,  3'd0, 4'd0,  8'd0);
      push_word(OP_WRITE, 3'd4, 4'd6,  8'd85);
      push_word(OP_TICK,  3'd0, 4'd0,  8'd0);
      wait_drained();

      // random segments with changing gap and stall rates
      seg = 0;
      while (random_done < RANDOM_ITEMS) begin
         if (random_done >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         case ($urandom_range(0, 3))
            0:       req_gap_pct = 0;
            1:       req_gap_pct = 15;
            2:       req_gap_pct = 40;
            default: req_gap_pct = 70;
         endcase
         case ($urandom_range(0, 3))
            0:       rsp_stall_pct = 0;
            1:       rsp_stall_pct = 15;
            2:       rsp_stall_pct = 40;
            default: rsp_stall_pct = 70;
         endcase
         if (seg == 4) begin
            // long rsp hold while ticks keep coming, fills the pipe
            hold_request = 1'b1;
            repeat (16) push_tick();
            random_done += 16;
         end
         if (seg == 9) wait_drained();
         seg_count = 0;
         while (seg_count < SEGMENT_ITEMS && random_done < RANDOM_ITEMS) begin
            sender_gap();
            push_random(counted);
            if (counted) begin
               seg_count++;
               random_done++;
            end
         end
         seg++;
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.lines_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d pixel writes (%0d off-matrix) and %0d ticks",
               tracker.writes, tracker.dropped_writes, tracker.ticks);
      $display("scan reached %0d blanking lines and %0d complete frames",
               tracker.blanks, tracker.frames);
      if (tracker.errors == 0) begin
         $display("led_matrix_pwm_scan_unit_tb: clean");
      end else begin
         $display("led_matrix_pwm_scan_unit_tb: errors");
      end
      $finish;
   end

endmodule
